>>> rtl/mmdp_pkg.sv
// Package for the min/max depth mip pyramid: widths, types and index helpers.
`default_nettype none
package mmdp_pkg;

   localparam int MAX_LOG2_RES = 10;
   localparam int DEPTH_W      = 24;
   localparam int LG_W         = 4;
   localparam int LEVEL_W      = 4;
   localparam int TEXEL_W      = 18;
   localparam int COORD_W      = MAX_LOG2_RES;
   localparam int SIDE_W       = COORD_W + 1;
   localparam int ADDR_W       = MAX_LOG2_RES;
   localparam int ROW_SLOTS    = 1 << MAX_LOG2_RES;
   localparam int LEVEL_SLOTS  = MAX_LOG2_RES - 1;
   localparam int SLOT_W       = $clog2(LEVEL_SLOTS);

   typedef struct packed {
      logic [DEPTH_W-1:0] entry_val;
      logic [DEPTH_W-1:0] exit_val;
   } depth_pair_type;

   typedef struct packed {
      logic                 en;
      logic [ADDR_W-1:0]    addr;
      depth_pair_type       data;
   } row_write_type;

   typedef struct packed {
      logic                 en;
      logic [ADDR_W-1:0]    addr;
   } row_read_type;

   function automatic logic [ADDR_W-1:0] row_slot(input logic [LG_W-1:0]    lg,
                                                  input logic [LEVEL_W-1:0] k,
                                                  input logic [COORD_W-1:0] x);
      logic [SIDE_W-1:0] side;
      logic [SIDE_W-1:0] base;
      logic [SIDE_W-1:0] sum;
      side = SIDE_W'(1) << lg;
      base = side - (side >> (k - LEVEL_W'(1)));
      sum  = base + {1'b0, x >> k};
      return sum[ADDR_W-1:0];
   endfunction

   function automatic logic [TEXEL_W-1:0] texel_at(input logic [LG_W-1:0]    lg,
                                                   input logic [LEVEL_W-1:0] k,
                                                   input logic [COORD_W-1:0] x,
                                                   input logic [COORD_W-1:0] y);
      logic [TEXEL_W-1:0] tx;
      logic [TEXEL_W-1:0] ty;
      tx = TEXEL_W'(x >> k);
      ty = TEXEL_W'(y >> k);
      return (ty << (lg - k)) | tx;
   endfunction

endpackage
`default_nettype wire

>>> rtl/mmdp_row_store.sv
// Row partial memory: even-row pair results of every level, one write and one read port.
`default_nettype none
module mmdp_row_store
   import mmdp_pkg::*;
(
   input  wire logic           clock,
   input  wire row_write_type  wr,
   input  wire row_read_type   rd,
   output      depth_pair_type rdata
);

   depth_pair_type mem [ROW_SLOTS];
   depth_pair_type rdata_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         rdata_ff <= mem[rd.addr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

>>> rtl/min_max_depth_mip_pyramid_core.sv
// Top level of the streaming min/max depth mip pyramid builder.
//
// Depth texels enter in raster order. An item that completes no 2x2 block is
// taken every cycle. An item that completes blocks on n levels occupies the
// level walker one level per cycle, and then holds or stores its last coarse
// texel on the level above when that level exists; the single read port of
// the row partial memory sets this pace. Each emitting level also waits while
// the output register holds a result not yet taken. Results leave lowest
// level first, each captured in the output register once the walker holds
// the item, the final one of an item flagged by rsp_last_of_run. A write of
// csr_wdata restarts the frame; write it only while idle. The partial memory
// needs no clearing pass.
`default_nettype none
module min_max_depth_mip_pyramid_core
   import mmdp_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_ready,
   input  wire logic [DEPTH_W-1:0] req_entry_depth,
   input  wire logic [DEPTH_W-1:0] req_exit_depth,
   output      logic               rsp_valid,
   input  wire logic               rsp_ready,
   output      logic [LEVEL_W-1:0] rsp_mip_level,
   output      logic [TEXEL_W-1:0] rsp_texel_index,
   output      logic [DEPTH_W-1:0] rsp_entry_max,
   output      logic [DEPTH_W-1:0] rsp_exit_min,
   output      logic               rsp_last_of_run,
   input  wire logic               csr_we,
   input  wire logic [LG_W-1:0]    csr_wdata
);

   logic [LG_W-1:0]    lg_ff, lg_in, lg_eff;
   logic [COORD_W-1:0] x_ff, x_in, y_ff, y_in;
   logic               busy_ff, busy_in;
   logic [LEVEL_W-1:0] lvl_ff, lvl_in;
   logic [COORD_W-1:0] wx_ff, wx_in, wy_ff, wy_in;
   depth_pair_type     cur_ff, cur_in;
   depth_pair_type     hold_ff [LEVEL_SLOTS];

   logic               rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0] rsp_level_ff;
   logic [TEXEL_W-1:0] rsp_texel_ff;
   depth_pair_type     rsp_data_ff;
   logic               rsp_last_ff;

   logic [SIDE_W-1:0]  side;
   logic [SLOT_W-1:0]  slot;
   logic [COORD_W-1:0] sx, sy;
   logic               active, col_odd, row_odd, emit, next_stops, finish, last_lvl;
   logic               out_free, advance, done, accept;
   depth_pair_type     pair, comb, held;
   depth_pair_type     rdata;
   row_write_type      wr;
   row_read_type       rd;

   assign lg_eff = (lg_ff > LG_W'(MAX_LOG2_RES)) ? LG_W'(MAX_LOG2_RES) : lg_ff;
   assign side   = SIDE_W'(1) << lg_eff;

   // level walker datapath
   always_comb begin
      slot       = SLOT_W'(lvl_ff - LEVEL_W'(1));
      sx         = wx_ff >> (lvl_ff - LEVEL_W'(1));
      sy         = wy_ff >> (lvl_ff - LEVEL_W'(1));
      active     = lvl_ff < lg_eff;
      col_odd    = sx[0];
      row_odd    = sy[0];
      held       = hold_ff[slot];
      pair.entry_val = (held.entry_val > cur_ff.entry_val) ? held.entry_val
                                                           : cur_ff.entry_val;
      pair.exit_val  = (held.exit_val < cur_ff.exit_val) ? held.exit_val
                                                         : cur_ff.exit_val;
      comb.entry_val = (rdata.entry_val > pair.entry_val) ? rdata.entry_val
                                                          : pair.entry_val;
      comb.exit_val  = (rdata.exit_val < pair.exit_val) ? rdata.exit_val
                                                        : pair.exit_val;
      emit       = busy_ff && active && col_odd && row_odd;
      last_lvl   = ({1'b0, lvl_ff} + 5'd1) >= {1'b0, lg_eff};
      next_stops = last_lvl || !sx[1] || !sy[1];
      finish     = !active || !col_odd || !row_odd || last_lvl;
      out_free   = !rsp_valid_ff || rsp_ready;
      advance    = busy_ff && (!emit || out_free);
      done       = advance && finish;
      req_ready  = !busy_ff || done;
      accept     = req_valid && req_ready;
   end

   // memory ports
   always_comb begin
      wr.en   = advance && active && col_odd && !row_odd;
      wr.addr = row_slot(lg_eff, lvl_ff, wx_ff);
      wr.data = pair;
      rd.en   = accept || (advance && emit && !finish);
      rd.addr = accept ? row_slot(lg_eff, LEVEL_W'(1), x_ff)
                       : row_slot(lg_eff, lvl_ff + LEVEL_W'(1), wx_ff);
   end

   mmdp_row_store u_row_store (
      .clock (clock),
      .wr    (wr),
      .rd    (rd),
      .rdata (rdata)
   );

   // next state
   always_comb begin
      lg_in   = lg_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      busy_in = busy_ff;
      lvl_in  = lvl_ff;
      wx_in   = wx_ff;
      wy_in   = wy_ff;
      cur_in  = cur_ff;
      if (accept) begin
         busy_in = 1'b1;
         lvl_in  = LEVEL_W'(1);
         wx_in   = x_ff;
         wy_in   = y_ff;
         cur_in.entry_val = req_entry_depth;
         cur_in.exit_val  = req_exit_depth;
         if (({1'b0, x_ff} + SIDE_W'(1)) >= side) begin
            x_in = '0;
            if (({1'b0, y_ff} + SIDE_W'(1)) >= side) begin
               y_in = '0;
            end else begin
               y_in = y_ff + COORD_W'(1);
            end
         end else begin
            x_in = x_ff + COORD_W'(1);
         end
      end else if (done) begin
         busy_in = 1'b0;
      end else if (advance) begin
         lvl_in = lvl_ff + LEVEL_W'(1);
         cur_in = comb;
      end
      if (csr_we) begin
         lg_in = csr_wdata;
         x_in  = '0;
         y_in  = '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lg_ff        <= LG_W'(MAX_LOG2_RES);
         x_ff         <= '0;
         y_ff         <= '0;
         busy_ff      <= 1'b0;
         lvl_ff       <= LEVEL_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         lg_ff        <= lg_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         busy_ff      <= busy_in;
         lvl_ff       <= lvl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wx_ff  <= wx_in;
      wy_ff  <= wy_in;
      cur_ff <= cur_in;
      if (advance && active && !col_odd) begin
         hold_ff[slot] <= cur_ff;
      end
      if (advance && emit) begin
         rsp_level_ff <= lvl_ff;
         rsp_texel_ff <= texel_at(lg_eff, lvl_ff, wx_ff, wy_ff);
         rsp_data_ff  <= comb;
         rsp_last_ff  <= next_stops;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_mip_level   = rsp_level_ff;
   assign rsp_texel_index = rsp_texel_ff;
   assign rsp_entry_max   = rsp_data_ff.entry_val;
   assign rsp_exit_min    = rsp_data_ff.exit_val;
   assign rsp_last_of_run = rsp_last_ff;

   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (wr.en && rd.en) |-> (wr.addr != rd.addr))
      else $error("row store read and write hit one entry in one cycle");

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (lvl_ff >= LEVEL_W'(1)) && ((lvl_ff < lg_eff) || (lvl_ff == LEVEL_W'(1))))
      else $error("walker level out of range");

   a_level_step: assert property (@(posedge clock) disable iff (reset)
      (advance && emit && !finish && !accept) |=> (lvl_ff == $past(lvl_ff) + LEVEL_W'(1)))
      else $error("walker failed to step to the next level");

   a_emit_slot_free: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> $stable(rsp_data_ff) && $stable(rsp_texel_ff))
      else $error("pending result overwritten");

endmodule
`default_nettype wire

>>> test/mip_pyramid_check.sv
// Checker for the depth mip pyramid: predicts coarse texels and compares each result item.
`timescale 1ns / 100ps
module mip_pyramid_check
   import mmdp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [DEPTH_W-1:0] req_entry_depth,
   input  logic [DEPTH_W-1:0] req_exit_depth,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [LEVEL_W-1:0] rsp_mip_level,
   input  logic [TEXEL_W-1:0] rsp_texel_index,
   input  logic [DEPTH_W-1:0] rsp_entry_max,
   input  logic [DEPTH_W-1:0] rsp_exit_min,
   input  logic               rsp_last_of_run,
   input  logic               csr_we,
   input  logic [LG_W-1:0]    csr_wdata,
   output int                 mismatches,
   output int                 outstanding
);

   localparam logic [LG_W-1:0] RESET_LOG2 = LG_W'(10);
   localparam int REPORT_LINES = 100;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic [TEXEL_W-1:0] texel;
      logic [DEPTH_W-1:0] entry_max;
      logic [DEPTH_W-1:0] exit_min;
      logic               last;
   } coarse_texel_type;

   logic [LG_W-1:0]    side_log2;
   int                 col_pos;
   int                 row_pos;
   logic [DEPTH_W-1:0] pair_entry [LEVEL_SLOTS];
   logic [DEPTH_W-1:0] pair_exit [LEVEL_SLOTS];
   logic [DEPTH_W-1:0] row_entry [ROW_SLOTS];
   logic [DEPTH_W-1:0] row_exit [ROW_SLOTS];
   coarse_texel_type   coarse_due [$];
   int                 fail_tally;

   initial begin
      fail_tally = 0;
      mismatches = 0;
      outstanding = 0;
   end

   task automatic report(input string field, input logic [31:0] want, input logic [31:0] got);
      fail_tally++;
      if (fail_tally <= REPORT_LINES) begin
         $display("mismatch on %s: expected 0x%0h, got 0x%0h at %0t", field, want, got, $time);
      end
   endtask

   task automatic check_result();
      coarse_texel_type want;
      if (coarse_due.size() == 0) begin
         report("unexpected result, texel_index", 32'd0, 32'(rsp_texel_index));
         return;
      end
      want = coarse_due.pop_front();
      if (rsp_mip_level !== want.level) begin
         report("mip_level", 32'(want.level), 32'(rsp_mip_level));
      end
      if (rsp_texel_index !== want.texel) begin
         report("texel_index", 32'(want.texel), 32'(rsp_texel_index));
      end
      if (rsp_entry_max !== want.entry_max) begin
         report("entry_max", 32'(want.entry_max), 32'(rsp_entry_max));
      end
      if (rsp_exit_min !== want.exit_min) begin
         report("exit_min", 32'(want.exit_min), 32'(rsp_exit_min));
      end
      if (rsp_last_of_run !== want.last) begin
         report("last_of_run", 32'(want.last), 32'(rsp_last_of_run));
      end
   endtask

   task automatic reduce_texel(input logic [DEPTH_W-1:0] entry_in,
                               input logic [DEPTH_W-1:0] exit_in);
      int                 lg;
      int                 side;
      int                 x;
      int                 y;
      int                 sx;
      int                 sy;
      int                 idx;
      int                 k;
      logic [DEPTH_W-1:0] cur_e;
      logic [DEPTH_W-1:0] cur_x;
      logic [DEPTH_W-1:0] pe;
      logic [DEPTH_W-1:0] px;
      coarse_texel_type   held;
      coarse_texel_type   fresh;
      bit                 have_held;
      lg = (side_log2 > MAX_LOG2_RES) ? MAX_LOG2_RES : int'(side_log2);
      side = 1 << lg;
      x = col_pos & (side - 1);
      y = row_pos & (side - 1);
      cur_e = entry_in;
      cur_x = exit_in;
      have_held = 1'b0;
      held = '0;
      for (k = 1; k < lg; k++) begin
         sx = x >> (k - 1);
         sy = y >> (k - 1);
         if (sx[0] == 1'b0) begin
            pair_entry[k-1] = cur_e;
            pair_exit[k-1] = cur_x;
            break;
         end
         pe = (pair_entry[k-1] > cur_e) ? pair_entry[k-1] : cur_e;
         px = (pair_exit[k-1] < cur_x) ? pair_exit[k-1] : cur_x;
         idx = (side - (side >> (k - 1)) + (sx >> 1)) & (ROW_SLOTS - 1);
         if (sy[0] == 1'b0) begin
            row_entry[idx] = pe;
            row_exit[idx] = px;
            break;
         end
         cur_e = (row_entry[idx] > pe) ? row_entry[idx] : pe;
         cur_x = (row_exit[idx] < px) ? row_exit[idx] : px;
         fresh.level = LEVEL_W'(k);
         fresh.texel = TEXEL_W'(((y >> k) << (lg - k)) | (x >> k));
         fresh.entry_max = cur_e;
         fresh.exit_min = cur_x;
         fresh.last = 1'b0;
         if (have_held) begin
            coarse_due.push_back(held);
         end
         held = fresh;
         have_held = 1'b1;
      end
      if (have_held) begin
         held.last = 1'b1;
         coarse_due.push_back(held);
      end
      // advance raster position
      x++;
      if (x >= side) begin
         x = 0;
         y++;
         if (y >= side) begin
            y = 0;
         end
      end
      col_pos = x;
      row_pos = y;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         side_log2 = RESET_LOG2;
         col_pos = 0;
         row_pos = 0;
         for (int i = 0; i < LEVEL_SLOTS; i++) begin
            pair_entry[i] = '0;
            pair_exit[i] = '0;
         end
         for (int i = 0; i < ROW_SLOTS; i++) begin
            row_entry[i] = '0;
            row_exit[i] = '0;
         end
         coarse_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            check_result();
         end
         if (csr_we) begin
            side_log2 = csr_wdata;
            col_pos = 0;
            row_pos = 0;
         end
         if (req_valid && req_ready) begin
            reduce_texel(req_entry_depth, req_exit_depth);
         end
      end
      mismatches <= fail_tally;
      outstanding <= coarse_due.size();
   end

endmodule

>>> test/testbench.sv
// Testbench top for the depth mip pyramid core: stimulus, handshake pacing and verdict.
`timescale 1ns / 100ps
module testbench
   import mmdp_pkg::*;
();

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SQUEEZE_CYCLES = 400;
   localparam int RANDOM_TEXELS  = 90;
   localparam int SETTLE_CYCLES  = 16;

   localparam logic [DEPTH_W-1:0] CORNER_ENTRY [16] = '{
      24'h000000, 24'hFFFFFF, 24'h123456, 24'h000001,
      24'h000001, 24'h000000, 24'h800000, 24'h7FFFFF,
      24'hAAAAAA, 24'h555555, 24'h000000, 24'h000000,
      24'h555555, 24'hFFFFFE, 24'h000000, 24'h000000
   };
   localparam logic [DEPTH_W-1:0] CORNER_EXIT [16] = '{
      24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'hFFFFFE,
      24'hFFFFFE, 24'hFFFFFF, 24'h7FFFFF, 24'h800000,
      24'h555555, 24'hAAAAAA, 24'hFFFFFF, 24'hFFFFFF,
      24'h000001, 24'hAAAAAA, 24'hFFFFFF, 24'hFFFFFF
   };

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [DEPTH_W-1:0] req_entry_depth;
   logic [DEPTH_W-1:0] req_exit_depth;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [LEVEL_W-1:0] rsp_mip_level;
   logic [TEXEL_W-1:0] rsp_texel_index;
   logic [DEPTH_W-1:0] rsp_entry_max;
   logic [DEPTH_W-1:0] rsp_exit_min;
   logic               rsp_last_of_run;
   logic               csr_we;
   logic [LG_W-1:0]    csr_wdata;

   int mismatches;
   int outstanding;
   int burst_left;
   int idle_cycles;
   bit squeeze_armed;

   min_max_depth_mip_pyramid_core u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_entry_depth (req_entry_depth),
      .req_exit_depth  (req_exit_depth),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_mip_level   (rsp_mip_level),
      .rsp_texel_index (rsp_texel_index),
      .rsp_entry_max   (rsp_entry_max),
      .rsp_exit_min    (rsp_exit_min),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata)
   );

   mip_pyramid_check u_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_entry_depth (req_entry_depth),
      .req_exit_depth  (req_exit_depth),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_mip_level   (rsp_mip_level),
      .rsp_texel_index (rsp_texel_index),
      .rsp_entry_max   (rsp_entry_max),
      .rsp_exit_min    (rsp_exit_min),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .mismatches      (mismatches),
      .outstanding     (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [DEPTH_W-1:0] pick_depth();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2:       return DEPTH_W'(1) << $urandom_range(0, DEPTH_W - 1);
         3:       return DEPTH_W'($urandom_range(0, 15));
         default: return DEPTH_W'($urandom);
      endcase
   endfunction

   function automatic int texel_budget(input int lg);
      int side;
      side = 1 << lg;
      case (lg)
         3:       return side * side;
         4, 5:    return side + int'($urandom_range(4, side));
         default: return int'($urandom_range(1, 8));
      endcase
   endfunction

   task automatic push_texel(input logic [DEPTH_W-1:0] entry_val,
                             input logic [DEPTH_W-1:0] exit_val);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? int'($urandom_range(100, 400))
                                                  : int'($urandom_range(1, 16));
      end
      burst_left--;
      req_valid <= 1'b1;
      req_entry_depth <= entry_val;
      req_exit_depth <= exit_val;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_resolution(input logic [LG_W-1:0] lg);
      drain();
      csr_wdata <= lg;
      csr_we <= 1'b1;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // receiver: random ready pattern, one long hold once armed
   initial begin
      int mode;
      int span;
      bit squeeze_done;
      squeeze_done = 1'b0;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (squeeze_armed && !squeeze_done) begin
            squeeze_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (SQUEEZE_CYCLES) @(posedge clock);
         end
         mode = $urandom_range(0, 3);
         span = $urandom_range(10, 150);
         repeat (span) begin
            if (squeeze_armed && !squeeze_done) break;
            case (mode)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= 1'($urandom_range(0, 1));
               2:       rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= ($urandom_range(0, 3) != 0);
            endcase
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
         end
      end
   end

   initial begin
      int count;
      int side;
      int random_texels;
      logic [LG_W-1:0] lg_pick;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_entry_depth <= '0;
      req_exit_depth <= '0;
      csr_we <= 1'b0;
      csr_wdata <= '0;
      burst_left = 0;
      squeeze_armed = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset resolution, then corner values on a 4x4 map, then maps too small to reduce
      for (int i = 0; i < 4; i++) begin
         push_texel(i[0] ? '1 : '0, i[0] ? '0 : '1);
      end
      write_resolution(LG_W'(2));
      for (int i = 0; i < 16; i++) begin
         push_texel(CORNER_ENTRY[i], CORNER_EXIT[i]);
      end
      write_resolution(LG_W'(0));
      push_texel('1, '0);
      push_texel('0, '1);
      write_resolution(LG_W'(1));
      push_texel('1, '1);
      push_texel('0, '0);

      for (int lg = 3; lg < 16; lg++) begin
         write_resolution(LG_W'(lg));
         count = texel_budget(lg);
         if (lg == 3) begin
            squeeze_armed = 1'b1;
         end
         repeat (count) push_texel(pick_depth(), pick_depth());
      end

      random_texels = 0;
      while (random_texels < RANDOM_TEXELS) begin
         lg_pick = ($urandom_range(0, 9) == 0) ? LG_W'($urandom_range(0, 1))
                                               : LG_W'($urandom_range(2, 5));
         side = 1 << lg_pick;
         count = $urandom_range(1, (2 * side * side < 120) ? 2 * side * side : 120);
         write_resolution(lg_pick);
         repeat (count) push_texel(pick_depth(), pick_depth());
         random_texels += count;
      end

      drain();
      if (mismatches == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/mmdp_pkg.sv
rtl/mmdp_row_store.sv
rtl/min_max_depth_mip_pyramid_core.sv
test/mip_pyramid_check.sv
test/testbench.sv
